@@ rtl/core/timer_min_heap_scheduler_assert.svh @@
// Assertion macros for the timer queue checker.
// Each macro expects clk and rst_n in scope.
`ifndef TIMER_MIN_HEAP_SCHEDULER_ASSERT_SVH
`define TIMER_MIN_HEAP_SCHEDULER_ASSERT_SVH

// Same-cycle implication: when ante holds, cons must hold too.
`define TMH_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timer queue check failed");

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define TMH_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timer queue check failed");

`endif

@@ rtl/core/tmh_pkg.sv @@
package tmh_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 16;
    localparam int DEFAULT_TAG_BITS    = 16;

    // Request codes
    localparam logic REQ_SET  = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Result codes
    localparam logic [1:0] KIND_SET_OK   = 2'd0;
    localparam logic [1:0] KIND_SET_FULL = 2'd1;
    localparam logic [1:0] KIND_FIRED    = 2'd2;

    typedef struct packed {
        logic        req_type;
        logic [31:0] delay_ms;
        logic [31:0] period_ms;
        logic [15:0] timer_tag;
    } tmh_req_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [15:0] fired_tag;
        logic        last_result;
    } tmh_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SET,
        ST_MARK,
        ST_SEL,
        ST_FIRE,
        ST_PACK
    } tmh_state_t;

endpackage

@@ rtl/core/tmh_ram.sv @@
module tmh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/timer_min_heap_scheduler.sv @@
// Timer queue: a set item is answered from ST_SET once the result register is
// free, and the next item is taken after that. A tick runs a mark pass over the
// N stored timers, then for each of its D due timers a select pass and a fire
// step, and a pack pass when a one-shot timer fired; its first fire result follows
// the first select pass. Each pass scans the entry RAM once; result stalls hold the set and fire steps.
// Reset (rst_n low, async) clears the tick and empties the queue, not the RAM.
module timer_min_heap_scheduler
    import tmh_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
    parameter int TAG_BITS    = DEFAULT_TAG_BITS
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  tmh_req_t req_item,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output tmh_rsp_t rsp_item
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    // Entry layout in RAM: {expiry, period, tag}
    localparam int ENT_W = 64 + TAG_BITS;

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    tmh_state_t state_reg, state_next;
    logic [31:0] now_reg, now_next;
    logic [CNT_W-1:0] count_reg, count_next;
    tmh_req_t req_reg, req_next;

    // One due bit and one removed bit per entry slot
    logic [QUEUE_DEPTH-1:0] due_reg, due_next;
    logic [QUEUE_DEPTH-1:0] removed_reg, removed_next;

    // Scan sequencer: scan_reg issues reads, pipe_* tracks the read data
    logic [CNT_W-1:0] scan_reg, scan_next;
    logic pipe_valid_reg, pipe_valid_next;
    logic [IDX_W-1:0] pipe_idx_reg, pipe_idx_next;

    // Running best candidate of the selection pass
    logic best_found_reg, best_found_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    logic [31:0] best_exp_reg, best_exp_next;
    logic [31:0] best_per_reg, best_per_next;
    logic [TAG_BITS-1:0] best_tag_reg, best_tag_next;

    // Write pointer of the compaction pass
    logic [CNT_W-1:0] kept_reg, kept_next;

    // Output register
    logic rsp_valid_reg, rsp_valid_next;
    tmh_rsp_t rsp_item_reg, rsp_item_next;

    // RAM port
    logic ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [ENT_W-1:0] ram_wdata;
    logic ram_re;
    logic [IDX_W-1:0] ram_raddr;
    logic [ENT_W-1:0] ram_rdata;

    logic [31:0] rd_exp;
    logic [31:0] rd_per;
    logic [TAG_BITS-1:0] rd_tag;
    logic [31:0] set_delay;
    logic rsp_free;
    logic scan_more;
    logic scan_done;
    logic rd_better;

    tmh_ram #(
        .WIDTH(ENT_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign rd_exp = ram_rdata[TAG_BITS+63:TAG_BITS+32];
    assign rd_per = ram_rdata[TAG_BITS+31:TAG_BITS];
    assign rd_tag = ram_rdata[TAG_BITS-1:0];

    // The output register can take a new result when empty or being drained
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign scan_more = (scan_reg < count_reg);
    assign scan_done = (scan_reg == count_reg) && !pipe_valid_reg;
    assign ram_raddr = scan_reg[IDX_W-1:0];

    // Zero delay falls back to the period
    assign set_delay = (req_reg.delay_ms != 32'd0) ? req_reg.delay_ms : req_reg.period_ms;

    // Comparator: earlier expiry wins, then lower tag, then lower slot
    assign rd_better = !best_found_reg || (rd_exp < best_exp_reg) ||
                       ((rd_exp == best_exp_reg) && (rd_tag < best_tag_reg));

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        now_next        = now_reg;
        count_next      = count_reg;
        req_next        = req_reg;
        due_next        = due_reg;
        removed_next    = removed_reg;
        scan_next       = scan_reg;
        pipe_valid_next = 1'b0;
        pipe_idx_next   = pipe_idx_reg;
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        best_exp_next   = best_exp_reg;
        best_per_next   = best_per_reg;
        best_tag_next   = best_tag_reg;
        kept_next       = kept_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        rsp_item_next   = rsp_item_reg;
        ram_we          = 1'b0;
        ram_waddr       = kept_reg[IDX_W-1:0];
        ram_wdata       = ram_rdata;
        ram_re          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_next = req_item;
                    case (req_item.req_type)
                        REQ_SET:
                        begin
                            state_next = ST_SET;
                        end
                        REQ_TICK:
                        begin
                            // Advance time, then snapshot the due set
                            now_next   = now_reg + 32'd1;
                            due_next   = '0;
                            scan_next  = '0;
                            state_next = ST_MARK;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_SET:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next            = 1'b1;
                    rsp_item_next.fired_tag   = 16'(TAG_BITS'(req_reg.timer_tag));
                    rsp_item_next.last_result = 1'b1;
                    if (count_reg >= CNT_W'(QUEUE_DEPTH))
                    begin
                        rsp_item_next.result_kind = KIND_SET_FULL;
                    end
                    else
                    begin
                        rsp_item_next.result_kind = KIND_SET_OK;
                        ram_we     = 1'b1;
                        ram_waddr  = count_reg[IDX_W-1:0];
                        ram_wdata  = {now_reg + set_delay, req_reg.period_ms,
                                      TAG_BITS'(req_reg.timer_tag)};
                        count_next = count_reg + CNT_W'(1);
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_MARK:
            begin
                if (scan_more)
                begin
                    ram_re          = 1'b1;
                    scan_next       = scan_reg + CNT_W'(1);
                    pipe_valid_next = 1'b1;
                    pipe_idx_next   = scan_reg[IDX_W-1:0];
                end
                if (pipe_valid_reg)
                begin
                    due_next[pipe_idx_reg] = (rd_exp <= now_reg);
                end
                if (scan_done)
                begin
                    scan_next       = '0;
                    best_found_next = 1'b0;
                    state_next      = (due_reg != '0) ? ST_SEL : ST_IDLE;
                end
            end

            ST_SEL:
            begin
                if (scan_more)
                begin
                    ram_re          = 1'b1;
                    scan_next       = scan_reg + CNT_W'(1);
                    pipe_valid_next = 1'b1;
                    pipe_idx_next   = scan_reg[IDX_W-1:0];
                end
                if (pipe_valid_reg && due_reg[pipe_idx_reg] && rd_better)
                begin
                    best_found_next = 1'b1;
                    best_idx_next   = pipe_idx_reg;
                    best_exp_next   = rd_exp;
                    best_per_next   = rd_per;
                    best_tag_next   = rd_tag;
                end
                if (scan_done)
                begin
                    state_next = ST_FIRE;
                end
            end

            ST_FIRE:
            begin
                if (rsp_free)
                begin
                    due_next[best_idx_reg] = 1'b0;
                    if (best_per_reg != 32'd0)
                    begin
                        // Re-arm in place; it is no longer due this tick
                        ram_we    = 1'b1;
                        ram_waddr = best_idx_reg;
                        ram_wdata = {now_reg + best_per_reg, best_per_reg, best_tag_reg};
                    end
                    else
                    begin
                        removed_next[best_idx_reg] = 1'b1;
                    end
                    rsp_valid_next            = 1'b1;
                    rsp_item_next.result_kind = KIND_FIRED;
                    rsp_item_next.fired_tag   = 16'(best_tag_reg);
                    rsp_item_next.last_result = (due_next == '0);
                    scan_next       = '0;
                    kept_next       = '0;
                    best_found_next = 1'b0;
                    if (due_next != '0)
                    begin
                        state_next = ST_SEL;
                    end
                    else if (removed_next != '0)
                    begin
                        state_next = ST_PACK;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_PACK:
            begin
                if (scan_more)
                begin
                    ram_re          = 1'b1;
                    scan_next       = scan_reg + CNT_W'(1);
                    pipe_valid_next = 1'b1;
                    pipe_idx_next   = scan_reg[IDX_W-1:0];
                end
                // Slide surviving entries down; writes never pass the read pointer
                if (pipe_valid_reg && !removed_reg[pipe_idx_reg])
                begin
                    ram_we    = 1'b1;
                    ram_waddr = kept_reg[IDX_W-1:0];
                    ram_wdata = ram_rdata;
                    kept_next = kept_reg + CNT_W'(1);
                end
                if (scan_done)
                begin
                    count_next   = kept_reg;
                    removed_next = '0;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            now_reg        <= '0;
            count_reg      <= '0;
            due_reg        <= '0;
            removed_reg    <= '0;
            scan_reg       <= '0;
            pipe_valid_reg <= 1'b0;
            best_found_reg <= 1'b0;
            kept_reg       <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            now_reg        <= now_next;
            count_reg      <= count_next;
            due_reg        <= due_next;
            removed_reg    <= removed_next;
            scan_reg       <= scan_next;
            pipe_valid_reg <= pipe_valid_next;
            best_found_reg <= best_found_next;
            kept_reg       <= kept_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // Payload registers hold without reset
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        pipe_idx_reg <= pipe_idx_next;
        best_idx_reg <= best_idx_next;
        best_exp_reg <= best_exp_next;
        best_per_reg <= best_per_next;
        best_tag_reg <= best_tag_next;
        rsp_item_reg <= rsp_item_next;
    end

    // Take a new item only while idle
    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_item  = rsp_item_reg;

endmodule

@@ rtl/core/tmh_checker.sv @@
`include "timer_min_heap_scheduler_assert.svh"

module tmh_checker
    import tmh_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     req_valid,
    input logic     req_stall,
    input tmh_req_t req_item,
    input logic     rsp_valid,
    input logic     rsp_stall,
    input tmh_rsp_t rsp_item
);

    logic req_taken;

    assign req_taken = req_valid && !req_stall &&
                       ((req_item.req_type == REQ_SET) || (req_item.req_type == REQ_TICK));

    // Hold a stalled result
    `TMH_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)
    `TMH_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall, $stable(rsp_item))

    // An accepted item keeps the block busy for at least the next cycle
    `TMH_ASSERT_NEXT(a_busy_after_accept, req_taken, req_stall)

    // A set answer is always the only, hence final, result of its item
    `TMH_ASSERT_NOW(a_set_is_last, rsp_valid && rsp_item.result_kind != KIND_FIRED, rsp_item.last_result)

endmodule

bind timer_min_heap_scheduler tmh_checker u_tmh_checker (.*);
